FILE: hw/rtl/pfa_pkg.sv
// Shared types, constants and helpers for the PID controller with feedforward.
// No dependencies; used by pfa_mul, pfa_div and pid_feedforward_antiwindup.
`timescale 1ns / 1ps
package pfa_pkg;

   localparam int DATA_W   = 32;
   localparam int DT_W     = 16;
   localparam int VAL_W    = 50;   // signed working values (rates, products, inner drag)
   localparam int A_W      = 33;   // magnitude of the narrow multiplier operand
   localparam int INT_W    = 48;
   localparam int SUM_W    = 52;
   localparam int DVD_W    = 49;   // |diff| << 16
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W    = 88;
   localparam int RSP_W    = 40;

   localparam logic [DT_W-1:0] DT_MIN = 16'd3277;
   localparam logic [DT_W-1:0] DT_MAX = 16'd13107;

   localparam logic signed [DATA_W-1:0] FF_REF_GAIN_DEF    = '0;
   localparam logic signed [DATA_W-1:0] FF_RATE_GAIN_DEF   = '0;
   localparam logic signed [DATA_W-1:0] DRAG_LIN_GAIN_DEF  = '0;
   localparam logic signed [DATA_W-1:0] DRAG_QUAD_GAIN_DEF = '0;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [CSR_IDX_W-1:0] REG_KP        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_UPPER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_LOWER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_UPPER = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LOWER = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_INC, ST_DIV_E, ST_DIV_R, ST_MUL_T1, ST_MUL_FF, ST_MUL_FFD,
      ST_MUL_Q, ST_MUL_DRAG, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic             sh16;   // shift by 16 instead of the fraction width
      logic [A_W-1:0]   a;
      logic [VAL_W-1:0] b;
   } mul_req_type;

   function automatic logic [VAL_W-1:0] mag_val(input logic signed [VAL_W-1:0] v);
      mag_val = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
   endfunction

   // magnitude trimmed to the narrow operand width
   function automatic logic [A_W-1:0] mag_a(input logic signed [VAL_W-1:0] v);
      mag_a = A_W'(mag_val(v));
   endfunction

endpackage

FILE: hw/rtl/pfa_mul.sv
// Sign-magnitude multiplier, 16 bits of the wide operand per cycle, with
// product and term saturation. Depends on pfa_pkg.
`timescale 1ns / 1ps
module pfa_mul #(
   parameter int FRAC_BITS = pfa_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pfa_pkg::mul_req_type              req,
   output logic                              done,
   output logic signed [pfa_pkg::VAL_W-1:0]  result
);
   localparam int B_W   = 64;
   localparam int ACC_W = pfa_pkg::A_W + B_W;
   localparam logic [62:0] PROD_CAP = {63{1'b1}} >> 1;
   localparam logic [46:0] TERM_CAP = {47{1'b1}};

   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [pfa_pkg::A_W-1:0] a_ff, a_in;
   logic [B_W-1:0]          b_ff, b_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic                    sh16_ff, sh16_in;
   logic [pfa_pkg::A_W+15:0] pp;
   logic [62:0]             capped, shifted;
   logic [46:0]             term;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      sh16_in = sh16_ff;
      done_in = 1'b0;
      pp      = a_ff * b_ff[B_W-1 -: 16];
      if (req.start) begin
         acc_in  = '0;
         a_in    = req.a;
         b_in    = B_W'(req.b);
         cnt_in  = '0;
         busy_in = 1'b1;
         neg_in  = req.neg;
         sh16_in = req.sh16;
      end else if (busy_ff) begin
         // take the top chunk first, shift the partial sum up
         acc_in = (acc_ff << 16) + ACC_W'(pp);
         b_in   = b_ff << 16;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      sh16_ff <= sh16_in;
   end

   always_comb begin
      capped  = (acc_ff > ACC_W'(PROD_CAP)) ? PROD_CAP : acc_ff[62:0];
      shifted = sh16_ff ? (capped >> 16) : (capped >> FRAC_BITS);
      term    = (shifted > 63'(TERM_CAP)) ? TERM_CAP : shifted[46:0];
      result  = neg_ff ? -$signed(pfa_pkg::VAL_W'(term)) : $signed(pfa_pkg::VAL_W'(term));
   end

   assign done = done_ff;

endmodule

FILE: hw/rtl/pfa_div.sv
// Restoring divider, one quotient bit per cycle, for the rate terms.
// Depends on pfa_pkg.
`timescale 1ns / 1ps
module pfa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pfa_pkg::DVD_W-1:0]     dividend,
   input  logic [pfa_pkg::DT_W-1:0]      divisor,
   output logic                          done,
   output logic [pfa_pkg::DVD_W-1:0]     quotient
);
   localparam int CNT_W = $clog2(pfa_pkg::DVD_W + 1);
   localparam int REM_W = pfa_pkg::DT_W + 1;

   logic [pfa_pkg::DVD_W-1:0] qn_ff, qn_in;
   logic [REM_W-1:0]          rem_ff, rem_in, rem_sh;
   logic [pfa_pkg::DT_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in, qbit;

   always_comb begin
      qn_in   = qn_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REM_W-2:0], qn_ff[pfa_pkg::DVD_W-1]};
      qbit    = rem_sh >= REM_W'(dsr_ff);
      if (start) begin
         qn_in   = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? rem_sh - REM_W'(dsr_ff) : rem_sh;
         qn_in  = {qn_ff[pfa_pkg::DVD_W-2:0], qbit};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(pfa_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      qn_ff  <= qn_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = qn_ff;

endmodule

FILE: hw/rtl/pid_feedforward_antiwindup.sv
// PID controller with reference/drag feedforward and anti-windup.
// Applied request: nine products on pfa_mul, two rate divisions on pfa_div, then
// the output state; one request in flight. Disabled or out-of-window request:
// result the cycle after accept.
// Synchronous reset clears gains, limits, integral and history to zero.
`timescale 1ns / 1ps
module pid_feedforward_antiwindup #(
   parameter logic signed [31:0] FF_REF_GAIN    = pfa_pkg::FF_REF_GAIN_DEF,
   parameter logic signed [31:0] FF_RATE_GAIN   = pfa_pkg::FF_RATE_GAIN_DEF,
   parameter logic signed [31:0] DRAG_LIN_GAIN  = pfa_pkg::DRAG_LIN_GAIN_DEF,
   parameter logic signed [31:0] DRAG_QUAD_GAIN = pfa_pkg::DRAG_QUAD_GAIN_DEF,
   parameter int                 FRAC_BITS      = pfa_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // enabled, error_in[31:0], reference[31:0], step_time[15:0], zero pad
   input  logic [pfa_pkg::REQ_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // command[31:0], applied, saturated, zero pad
   output logic [pfa_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_we,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pfa_pkg::DATA_W-1:0]        csr_wdata
);
   localparam int VW = pfa_pkg::VAL_W;
   localparam int IW = pfa_pkg::INT_W;
   localparam int SW = pfa_pkg::SUM_W;

   pfa_pkg::state_type state_ff, state_in;

   logic signed [31:0] kp_ff, ki_ff, kd_ff, eu_ff, el_ff, ou_ff, ol_ff;
   logic signed [31:0] err_ff, err_in, ref_ff, ref_in, last_err_ff, last_ref_ff;
   logic signed [31:0] ein_ff, ein_in;
   logic [15:0]        dt_ff, dt_in;
   logic signed [IW-1:0] int_ff, new_int_ff, new_int_in;
   logic signed [VW-1:0] rate_e_ff, rate_e_in, rate_r_ff, rate_r_in, tmp_ff, tmp_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic               wait_ff, wait_in, upd;
   logic               rsp_valid_ff, rsp_valid_in, cmd_sat;
   logic [pfa_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [31:0] cmd;

   logic signed [31:0] e_in, r_in;
   logic [15:0]        d_in;
   logic               run, accept, slot_free;
   logic signed [VW-1:0] err_v, ref_v, cur_v, diff_v;
   logic signed [IW:0]   int_sum;

   pfa_pkg::mul_req_type mreq;
   logic               mul_done, div_start, div_done, div_neg;
   logic signed [VW-1:0] mul_res;
   logic [pfa_pkg::DVD_W-1:0] div_dvd, div_q;

   pfa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .req(mreq), .done(mul_done), .result(mul_res)
   );

   pfa_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(dt_ff), .done(div_done), .quotient(div_q)
   );

   assign e_in = req_tdata[32:1];
   assign r_in = req_tdata[64:33];
   assign d_in = req_tdata[80:65];
   assign run  = req_tdata[0] && (d_in >= pfa_pkg::DT_MIN) && (d_in <= pfa_pkg::DT_MAX);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == pfa_pkg::ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   assign err_v   = VW'(err_ff);
   assign ref_v   = VW'(ref_ff);
   // drag acts on the raw error, not the clamped one
   assign cur_v   = VW'(ein_ff) + VW'(ref_ff);
   assign int_sum = (IW+1)'(int_ff) + (IW+1)'(mul_res);
   assign div_neg = diff_v[VW-1];

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      ein_in       = ein_ff;
      ref_in       = ref_ff;
      dt_in        = dt_ff;
      new_int_in   = new_int_ff;
      rate_e_in    = rate_e_ff;
      rate_r_in    = rate_r_ff;
      tmp_in       = tmp_ff;
      sum_in       = sum_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      upd          = 1'b0;
      mreq         = '0;
      div_start    = 1'b0;
      diff_v       = (state_ff == pfa_pkg::ST_DIV_E) ? VW'(err_ff) - VW'(last_err_ff)
                                                    : VW'(ref_ff) - VW'(last_ref_ff);
      div_dvd      = {pfa_pkg::mag_a(diff_v), 16'd0};
      cmd          = '0;
      cmd_sat      = 1'b0;

      // operand select for the current product
      case (state_ff)
         pfa_pkg::ST_MUL_INC: begin
            mreq.a = pfa_pkg::mag_a(err_v);
            mreq.b = VW'(dt_ff);
            mreq.neg = err_ff[31];
            mreq.sh16 = 1'b1;
         end
         pfa_pkg::ST_MUL_T1: begin
            mreq.a = pfa_pkg::mag_a(ref_v);
            mreq.b = pfa_pkg::mag_val(VW'(FF_REF_GAIN));
            mreq.neg = FF_REF_GAIN[31];
         end
         pfa_pkg::ST_MUL_FF: begin
            mreq.a = pfa_pkg::mag_a(ref_v);
            mreq.b = pfa_pkg::mag_val(tmp_ff);
            mreq.neg = tmp_ff[VW-1] != ref_ff[31];
         end
         pfa_pkg::ST_MUL_FFD: begin
            mreq.a = pfa_pkg::mag_a(VW'(FF_RATE_GAIN));
            mreq.b = pfa_pkg::mag_val(rate_r_ff);
            mreq.neg = FF_RATE_GAIN[31] != rate_r_ff[VW-1];
         end
         pfa_pkg::ST_MUL_Q: begin
            mreq.a = pfa_pkg::mag_a(cur_v);
            mreq.b = pfa_pkg::mag_val(VW'(DRAG_QUAD_GAIN));
            mreq.neg = DRAG_QUAD_GAIN[31];
         end
         pfa_pkg::ST_MUL_DRAG: begin
            mreq.a = pfa_pkg::mag_a(cur_v);
            mreq.b = pfa_pkg::mag_val(tmp_ff);
            mreq.neg = tmp_ff[VW-1] != cur_v[VW-1];
         end
         pfa_pkg::ST_MUL_P: begin
            mreq.a = pfa_pkg::mag_a(err_v);
            mreq.b = pfa_pkg::mag_val(VW'(kp_ff));
            mreq.neg = kp_ff[31] != err_ff[31];
         end
         pfa_pkg::ST_MUL_I: begin
            mreq.a = pfa_pkg::mag_a(VW'(ki_ff));
            mreq.b = pfa_pkg::mag_val(VW'(new_int_ff));
            mreq.neg = ki_ff[31] != new_int_ff[IW-1];
         end
         pfa_pkg::ST_MUL_D: begin
            mreq.a = pfa_pkg::mag_a(VW'(kd_ff));
            mreq.b = pfa_pkg::mag_val(rate_e_ff);
            mreq.neg = kd_ff[31] != rate_e_ff[VW-1];
         end
         default: begin
            mreq = '0;
         end
      endcase

      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept) begin
               if (run) begin
                  if (e_in < el_ff) begin
                     err_in = el_ff;
                  end else if (e_in > eu_ff) begin
                     err_in = eu_ff;
                  end else begin
                     err_in = e_in;
                  end
                  ein_in   = e_in;
                  ref_in   = r_in;
                  dt_in    = d_in;
                  sum_in   = '0;
                  wait_in  = 1'b0;
                  state_in = pfa_pkg::ST_MUL_INC;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end
            end
         end
         pfa_pkg::ST_DIV_E, pfa_pkg::ST_DIV_R: begin
            if (!wait_ff) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else if (div_done) begin
               wait_in = 1'b0;
               if (state_ff == pfa_pkg::ST_DIV_E) begin
                  rate_e_in = div_neg ? -$signed(VW'(div_q)) : $signed(VW'(div_q));
                  state_in  = pfa_pkg::ST_DIV_R;
               end else begin
                  rate_r_in = div_neg ? -$signed(VW'(div_q)) : $signed(VW'(div_q));
                  state_in  = pfa_pkg::ST_MUL_T1;
               end
            end
         end
         pfa_pkg::ST_OUT: begin
            if (slot_free) begin
               if (sum_ff > SW'(ou_ff)) begin
                  cmd = ou_ff;
                  cmd_sat = 1'b1;
               end else if (sum_ff < SW'(ol_ff)) begin
                  cmd = ol_ff;
                  cmd_sat = 1'b1;
               end else begin
                  cmd = sum_ff[31:0];
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, cmd_sat, 1'b1, cmd};
               upd          = 1'b1;
               state_in     = pfa_pkg::ST_IDLE;
            end
         end
         default: begin
            // product states: issue, then fold the result in when it lands
            if (!wait_ff) begin
               mreq.start = 1'b1;
               wait_in    = 1'b1;
            end else if (mul_done) begin
               wait_in = 1'b0;
               case (state_ff)
                  pfa_pkg::ST_MUL_INC: begin
                     if (int_sum[IW] != int_sum[IW-1]) begin
                        new_int_in = {int_sum[IW], {(IW-1){!int_sum[IW]}}};
                     end else begin
                        new_int_in = int_sum[IW-1:0];
                     end
                     state_in = pfa_pkg::ST_DIV_E;
                  end
                  pfa_pkg::ST_MUL_T1: begin
                     tmp_in   = mul_res;
                     state_in = pfa_pkg::ST_MUL_FF;
                  end
                  pfa_pkg::ST_MUL_FF: begin
                     sum_in   = sum_ff + SW'(mul_res);
                     state_in = pfa_pkg::ST_MUL_FFD;
                  end
                  pfa_pkg::ST_MUL_FFD: begin
                     sum_in   = sum_ff + SW'(mul_res);
                     state_in = pfa_pkg::ST_MUL_Q;
                  end
                  pfa_pkg::ST_MUL_Q: begin
                     tmp_in   = VW'(DRAG_LIN_GAIN) + mul_res;
                     state_in = pfa_pkg::ST_MUL_DRAG;
                  end
                  pfa_pkg::ST_MUL_DRAG: begin
                     sum_in   = sum_ff + SW'(mul_res);
                     state_in = pfa_pkg::ST_MUL_P;
                  end
                  pfa_pkg::ST_MUL_P: begin
                     sum_in   = sum_ff + SW'(mul_res);
                     state_in = pfa_pkg::ST_MUL_I;
                  end
                  pfa_pkg::ST_MUL_I: begin
                     sum_in   = sum_ff + SW'(mul_res);
                     state_in = pfa_pkg::ST_MUL_D;
                  end
                  default: begin
                     sum_in   = sum_ff + SW'(mul_res);
                     state_in = pfa_pkg::ST_OUT;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kp_ff <= '0; ki_ff <= '0; kd_ff <= '0;
         eu_ff <= '0; el_ff <= '0; ou_ff <= '0; ol_ff <= '0;
         int_ff      <= '0;
         last_err_ff <= '0;
         last_ref_ff <= '0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               pfa_pkg::REG_KP:        kp_ff <= csr_wdata;
               pfa_pkg::REG_KI:        ki_ff <= csr_wdata;
               pfa_pkg::REG_KD:        kd_ff <= csr_wdata;
               pfa_pkg::REG_ERR_UPPER: eu_ff <= csr_wdata;
               pfa_pkg::REG_ERR_LOWER: el_ff <= csr_wdata;
               pfa_pkg::REG_OUT_UPPER: ou_ff <= csr_wdata;
               pfa_pkg::REG_OUT_LOWER: ol_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (upd) begin
            // drop this step's integral increment when the output clamps
            if (!cmd_sat) begin
               int_ff <= new_int_ff;
            end
            last_err_ff <= err_ff;
            last_ref_ff <= ref_ff;
         end
      end
      err_ff      <= err_in;
      ein_ff      <= ein_in;
      ref_ff      <= ref_in;
      dt_ff       <= dt_in;
      new_int_ff  <= new_int_in;
      rate_e_ff   <= rate_e_in;
      rate_r_ff   <= rate_r_in;
      tmp_ff      <= tmp_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
